/* design/gff_pkg.sv */
// Shared constants, codes, command and status types, and the color fold for the flood fill unit.
package gff_pkg;

    localparam int GRID_ROWS_DEF   = 16;
    localparam int GRID_COLS_DEF   = 16;
    localparam int COLOR_COUNT_DEF = 8;

    localparam int FUNC_W  = 2;
    localparam int ROW_W   = 4;
    localparam int COL_W   = 4;
    localparam int COLOR_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FILL  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] NBR_UP    = 2'd0;
    localparam logic [1:0] NBR_DOWN  = 2'd1;
    localparam logic [1:0] NBR_LEFT  = 2'd2;
    localparam logic [1:0] NBR_RIGHT = 2'd3;

    typedef struct packed {
        logic       load;
        logic       item_wr;
        logic       item_rd;
        logic       corner_rd;
        logic       corner_fill;
        logic       pop;
        logic       nbr_rd;
        logic [1:0] nbr_sel;
        logic       scan_rd;
        logic       out_load;
    } gff_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              corner_match;
        logic              stack_empty;
        logic              scan_last;
        logic              out_free;
    } gff_status_t;

    // Reduces a color into the palette by repeated subtraction.
    function automatic logic [COLOR_W-1:0] fold_color(logic [COLOR_W-1:0] c, int cc);
        logic [COLOR_W-1:0] v;
        v = c;
        for (int i = 0; i < 4; i++)
        begin
            if (int'(v) >= cc)
            begin
                v = v - COLOR_W'(cc);
            end
        end
        return v;
    endfunction

endpackage

/* design/gff_ctrl.sv */
// Controller state machine that sequences write, read, fill and uniformity scan.
module gff_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gff_pkg::gff_status_t status,
    output gff_pkg::gff_cmd_t    cmd
);
    import gff_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_EXEC     = 4'd1;
    localparam logic [3:0] ST_CORNER   = 4'd2;
    localparam logic [3:0] ST_POP      = 4'd3;
    localparam logic [3:0] ST_NBR      = 4'd4;
    localparam logic [3:0] ST_SCAN     = 4'd5;
    localparam logic [3:0] ST_SCAN_END = 4'd6;
    localparam logic [3:0] ST_RESP     = 4'd7;

    localparam logic [2:0] PHASE_LAST = 3'd4;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [2:0] phase_reg;
    logic [2:0] phase_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (status.func)
                    FUNC_WRITE:
                    begin
                        cmd.item_wr = 1'b1;
                        state_next  = ST_RESP;
                    end
                    FUNC_READ:
                    begin
                        cmd.item_rd = 1'b1;
                        state_next  = ST_RESP;
                    end
                    FUNC_FILL:
                    begin
                        cmd.corner_rd = 1'b1;
                        state_next    = ST_CORNER;
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_CORNER:
            begin
                if (status.corner_match)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    cmd.corner_fill = 1'b1;
                    state_next      = ST_POP;
                end
            end
            ST_POP:
            begin
                if (status.stack_empty)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    phase_next = '0;
                    state_next = ST_NBR;
                end
            end
            ST_NBR:
            begin
                if (phase_reg == PHASE_LAST)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.nbr_rd  = 1'b1;
                    cmd.nbr_sel = phase_reg[1:0];
                    phase_next  = phase_reg + 3'd1;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/gff_datapath.sv */
// Datapath with the board and fill stack memories, neighbor addressing, scan and result register.
module gff_datapath #(
    parameter int GRID_ROWS   = gff_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS   = gff_pkg::GRID_COLS_DEF,
    parameter int COLOR_COUNT = gff_pkg::COLOR_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [gff_pkg::FUNC_W-1:0]   func,
    input  logic [gff_pkg::ROW_W-1:0]    row,
    input  logic [gff_pkg::COL_W-1:0]    col,
    input  logic [gff_pkg::COLOR_W-1:0]  color,
    input  gff_pkg::gff_cmd_t            cmd,
    output gff_pkg::gff_status_t         status,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [gff_pkg::COLOR_W-1:0]  cell_color,
    output logic                         all_uniform
);
    import gff_pkg::*;

    localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int R_W        = $clog2(GRID_ROWS);
    localparam int C_W        = $clog2(GRID_COLS);
    localparam int STK_W      = R_W + C_W;

    logic [COLOR_W-1:0] board_mem [CELL_COUNT];
    logic [STK_W-1:0]   stack_mem [CELL_COUNT];

    logic [FUNC_W-1:0]  func_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] from_reg;
    logic               uniform_reg;
    logic               chk_reg;
    logic [CELL_W-1:0]  scan_cnt_reg;
    logic [CELL_W:0]    stack_top_reg;
    logic [CELL_W:0]    stack_top_next;
    logic               pend_valid_reg;
    logic [R_W-1:0]     pend_r_reg;
    logic [C_W-1:0]     pend_c_reg;
    logic [CELL_W-1:0]  pend_idx_reg;
    logic [COLOR_W-1:0] brd_rdata_reg;
    logic [STK_W-1:0]   stk_rdata_reg;
    logic               out_valid_reg;
    logic [COLOR_W-1:0] cell_color_reg;
    logic               all_uniform_reg;

    logic               in_grid;
    logic [CELL_W-1:0]  item_idx;
    logic [R_W-1:0]     cur_r;
    logic [C_W-1:0]     cur_c;
    logic [R_W-1:0]     nbr_r;
    logic [C_W-1:0]     nbr_c;
    logic               nbr_ok;
    logic [CELL_W-1:0]  nbr_idx;
    logic               hit;
    logic               brd_we;
    logic [CELL_W-1:0]  brd_waddr;
    logic               brd_re;
    logic [CELL_W-1:0]  brd_raddr;
    logic               push;
    logic [STK_W-1:0]   push_data;
    logic [CELL_W-1:0]  stk_raddr;

    assign in_grid  = (int'(row_reg) < GRID_ROWS) && (int'(col_reg) < GRID_COLS);
    assign item_idx = CELL_W'(int'(row_reg) * GRID_COLS + int'(col_reg));

    assign cur_r = stk_rdata_reg[STK_W-1:C_W];
    assign cur_c = stk_rdata_reg[C_W-1:0];

    always_comb
    begin
        nbr_r  = cur_r;
        nbr_c  = cur_c;
        nbr_ok = 1'b0;
        case (cmd.nbr_sel)
            NBR_UP:
            begin
                nbr_r  = cur_r - 1'b1;
                nbr_ok = (cur_r != '0);
            end
            NBR_DOWN:
            begin
                nbr_r  = cur_r + 1'b1;
                nbr_ok = (cur_r != R_W'(GRID_ROWS - 1));
            end
            NBR_LEFT:
            begin
                nbr_c  = cur_c - 1'b1;
                nbr_ok = (cur_c != '0);
            end
            default:
            begin
                nbr_c  = cur_c + 1'b1;
                nbr_ok = (cur_c != C_W'(GRID_COLS - 1));
            end
        endcase
    end

    assign nbr_idx = CELL_W'(int'(nbr_r) * GRID_COLS + int'(nbr_c));

    assign hit = pend_valid_reg && (brd_rdata_reg == from_reg);

    always_comb
    begin
        brd_we    = 1'b0;
        brd_waddr = '0;
        if (cmd.item_wr && in_grid)
        begin
            brd_we    = 1'b1;
            brd_waddr = item_idx;
        end
        else if (cmd.corner_fill)
        begin
            brd_we = 1'b1;
        end
        else if (hit)
        begin
            brd_we    = 1'b1;
            brd_waddr = pend_idx_reg;
        end
    end

    always_comb
    begin
        brd_re    = 1'b0;
        brd_raddr = '0;
        if (cmd.item_rd && in_grid)
        begin
            brd_re    = 1'b1;
            brd_raddr = item_idx;
        end
        else if (cmd.corner_rd)
        begin
            brd_re = 1'b1;
        end
        else if (cmd.nbr_rd && nbr_ok)
        begin
            brd_re    = 1'b1;
            brd_raddr = nbr_idx;
        end
        else if (cmd.scan_rd)
        begin
            brd_re    = 1'b1;
            brd_raddr = scan_cnt_reg;
        end
    end

    assign push      = (cmd.corner_fill || hit) && (stack_top_reg != (CELL_W + 1)'(CELL_COUNT));
    assign push_data = cmd.corner_fill ? '0 : {pend_r_reg, pend_c_reg};
    assign stk_raddr = stack_top_next[CELL_W-1:0];

    always_comb
    begin
        stack_top_next = stack_top_reg;
        if (push)
        begin
            stack_top_next = stack_top_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            stack_top_next = stack_top_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (brd_we)
        begin
            board_mem[brd_waddr] <= color_reg;
        end
        if (brd_re)
        begin
            brd_rdata_reg <= board_mem[brd_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[stack_top_reg[CELL_W-1:0]] <= push_data;
        end
        if (cmd.pop)
        begin
            stk_rdata_reg <= stack_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            row_reg   <= row;
            col_reg   <= col;
            color_reg <= fold_color(color, COLOR_COUNT);
        end
        if (cmd.corner_fill)
        begin
            from_reg <= brd_rdata_reg;
        end
        if (cmd.nbr_rd)
        begin
            pend_r_reg   <= nbr_r;
            pend_c_reg   <= nbr_c;
            pend_idx_reg <= nbr_idx;
        end
        if (cmd.out_load)
        begin
            cell_color_reg  <= (func_reg == FUNC_READ && in_grid) ? brd_rdata_reg : '0;
            all_uniform_reg <= (func_reg == FUNC_FILL) ? uniform_reg : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_top_reg  <= '0;
            pend_valid_reg <= 1'b0;
            chk_reg        <= 1'b0;
            scan_cnt_reg   <= '0;
            uniform_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            stack_top_reg  <= stack_top_next;
            pend_valid_reg <= cmd.nbr_rd && nbr_ok;
            chk_reg        <= cmd.scan_rd;
            if (cmd.load)
            begin
                scan_cnt_reg <= '0;
                uniform_reg  <= 1'b1;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (chk_reg && (brd_rdata_reg != color_reg))
                begin
                    uniform_reg <= 1'b0;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.func         = func_reg;
    assign status.corner_match = (brd_rdata_reg == color_reg);
    assign status.stack_empty  = (stack_top_reg == '0);
    assign status.scan_last    = (scan_cnt_reg == CELL_W'(CELL_COUNT - 1));
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign cell_color  = cell_color_reg;
    assign all_uniform = all_uniform_reg;

endmodule

/* design/grid_flood_fill_from_corner_unit.sv */
// Top level of the corner flood fill unit: controller and datapath.
// Write, read and unknown items pass through execute and response states to the result register.
// A fill recolors the connected corner region by a stack walk of the board, then runs
// a one-cell-per-cycle uniformity scan over every cell of the board.
// One item is worked at a time; the next is taken while a result waits in the output register.
// Reset clears control state only; board cells are undefined until written, with no clearing pass.
module grid_flood_fill_from_corner_unit #(
    parameter int GRID_ROWS   = gff_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS   = gff_pkg::GRID_COLS_DEF,
    parameter int COLOR_COUNT = gff_pkg::COLOR_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [gff_pkg::FUNC_W-1:0]   func,
    input  logic [gff_pkg::ROW_W-1:0]    row,
    input  logic [gff_pkg::COL_W-1:0]    col,
    input  logic [gff_pkg::COLOR_W-1:0]  color,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [gff_pkg::COLOR_W-1:0]  cell_color,
    output logic                         all_uniform
);
    import gff_pkg::*;

    gff_cmd_t    cmd;
    gff_status_t status;

    gff_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    gff_datapath #(
        .GRID_ROWS   (GRID_ROWS),
        .GRID_COLS   (GRID_COLS),
        .COLOR_COUNT (COLOR_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .func        (func),
        .row         (row),
        .col         (col),
        .color       (color),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_color  (cell_color),
        .all_uniform (all_uniform)
    );

endmodule
